@@ hdl/mexp_pkg.sv @@
// Package with the sequencer states and fixed constants of the modular exponentiation core.
`timescale 1ns / 1ps
`default_nettype none

package mexp_pkg;

    // Modulus after reset, cut to the operand width by the user.
    localparam logic [63:0] RESET_MODULUS = 64'd1000000007;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RED_ISSUE,
        ST_RED_WAIT,
        ST_SQ_ISSUE,
        ST_SQ_WAIT,
        ST_MUL_ISSUE,
        ST_MUL_WAIT,
        ST_DELIVER
    } mexp_state_t;

    typedef struct packed {
        logic start;
    } mexp_mul_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mexp_mul_stat_t;

endpackage

`default_nettype wire

@@ hdl/mexp_mulmod.sv @@
// Bit-serial modular multiplier that consumes one multiplier bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module mexp_mulmod #(
    parameter int WIDTH = 32
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire mexp_pkg::mexp_mul_ctrl_t ctrl,
    input  wire logic [WIDTH-1:0]        a,
    input  wire logic [WIDTH-1:0]        b,
    input  wire logic [WIDTH-1:0]        m,
    output mexp_pkg::mexp_mul_stat_t      stat,
    output logic [WIDTH-1:0]             product
);

    localparam int CW = $clog2(WIDTH);
    localparam logic [CW-1:0] LAST_BIT = CW'(WIDTH - 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CW-1:0]    cnt_reg;
    logic [WIDTH-1:0] a_reg;
    logic [WIDTH-1:0] b_reg;
    logic [WIDTH-1:0] m_reg;
    logic [WIDTH-1:0] r_reg;
    logic [WIDTH-1:0] r_next;

    logic [WIDTH:0]   dbl_sum;
    logic [WIDTH-1:0] dbl_mod;
    logic [WIDTH:0]   add_sum;
    logic [WIDTH-1:0] add_mod;

    // Double the partial sum, then add the multiplicand when the bit is set.
    always_comb
    begin
        dbl_sum = {1'b0, r_reg} + {1'b0, r_reg};
        if (dbl_sum >= {1'b0, m_reg})
        begin
            dbl_sum = dbl_sum - {1'b0, m_reg};
        end
        dbl_mod = dbl_sum[WIDTH-1:0];
        add_sum = {1'b0, dbl_mod} + {1'b0, a_reg};
        if (add_sum >= {1'b0, m_reg})
        begin
            add_sum = add_sum - {1'b0, m_reg};
        end
        add_mod = add_sum[WIDTH-1:0];
        r_next = b_reg[WIDTH-1] ? add_mod : dbl_mod;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == LAST_BIT)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            a_reg <= a;
            b_reg <= b;
            m_reg <= m;
            r_reg <= '0;
        end
        else if (busy_reg)
        begin
            b_reg <= {b_reg[WIDTH-2:0], 1'b0};
            r_reg <= r_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign product   = r_reg;

endmodule

`default_nettype wire

@@ hdl/modular_exponentiation_core.sv @@
// Modular exponentiation core: base to the exponent modulo a programmable modulus.
//
// An item on the input channel carries base_value and exponent; it is taken when
// in_valid is high and in_stall is low. One item is worked on at a time, and
// in_stall stays high from acceptance until the sequencer is idle again.
// The base is first reduced by the modulus, then the exponent is scanned from
// its top bit down with a square for every bit and a multiply for every set bit.
// Every modular product runs on one shared bit-serial multiplier, with an issue step
// that starts it and a wait step that takes its product when it is done.
// A modulus of zero skips the work and goes straight to the last step with a zero result.
// The result sits in an output register; a new item is accepted while it waits.
// If out_stall holds off a finished result while a second one is ready, the
// sequencer waits in its last step until the output register is free.
// Reset clears the channel state and loads the modulus with 1000000007.
// The user writes the modulus through modulus_write and modulus while the core is idle; the core does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module modular_exponentiation_core #(
    parameter int OPERAND_WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     modulus_write,
    input  wire logic [OPERAND_WIDTH-1:0] modulus,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [OPERAND_WIDTH-1:0] base_value,
    input  wire logic [OPERAND_WIDTH-1:0] exponent,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic [OPERAND_WIDTH-1:0]      power_result
);

    localparam int W  = OPERAND_WIDTH;
    localparam int CW = $clog2(W);
    localparam logic [CW-1:0] LAST_BIT = CW'(W - 1);

    mexp_pkg::mexp_state_t    state_reg;
    mexp_pkg::mexp_state_t    state_next;
    logic [W-1:0]             modulus_reg;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [W-1:0]             result_reg;
    logic [W-1:0]             result_next;
    logic [W-1:0]             base_reg;
    logic [W-1:0]             base_next;
    logic [W-1:0]             exp_reg;
    logic [W-1:0]             exp_next;
    logic [CW-1:0]            cnt_reg;
    logic [CW-1:0]            cnt_next;
    logic [W-1:0]             res_reg;
    logic [W-1:0]             res_next;
    logic [W-1:0]             one_mod;
    logic                     accept;
    logic                     out_free;
    mexp_pkg::mexp_mul_ctrl_t mul_ctrl;
    mexp_pkg::mexp_mul_stat_t mul_stat;
    logic [W-1:0]             mul_a;
    logic [W-1:0]             mul_b;
    logic [W-1:0]             mul_product;

    mexp_mulmod #(
        .WIDTH(W)
    ) u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (mul_ctrl),
        .a       (mul_a),
        .b       (mul_b),
        .m       (modulus_reg),
        .stat    (mul_stat),
        .product (mul_product)
    );

    assign one_mod  = {{(W - 1){1'b0}}, (modulus_reg != W'(1))};
    assign accept   = in_valid && (state_reg == mexp_pkg::ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        base_next      = base_reg;
        exp_next       = exp_reg;
        cnt_next       = cnt_reg;
        res_next       = res_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg && out_stall;
        mul_ctrl.start = 1'b0;
        mul_a          = res_reg;
        mul_b          = res_reg;

        unique case (state_reg)
            mexp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    base_next = base_value;
                    exp_next  = exponent;
                    cnt_next  = '0;
                    res_next  = one_mod;
                    if (modulus_reg == '0)
                    begin
                        res_next   = '0;
                        state_next = mexp_pkg::ST_DELIVER;
                    end
                    else
                    begin
                        state_next = mexp_pkg::ST_RED_ISSUE;
                    end
                end
            end
            mexp_pkg::ST_RED_ISSUE:
            begin
                mul_ctrl.start = 1'b1;
                mul_a          = one_mod;
                mul_b          = base_reg;
                state_next     = mexp_pkg::ST_RED_WAIT;
            end
            mexp_pkg::ST_RED_WAIT:
            begin
                if (mul_stat.done)
                begin
                    base_next  = mul_product;
                    state_next = mexp_pkg::ST_SQ_ISSUE;
                end
            end
            mexp_pkg::ST_SQ_ISSUE:
            begin
                mul_ctrl.start = 1'b1;
                state_next     = mexp_pkg::ST_SQ_WAIT;
            end
            mexp_pkg::ST_SQ_WAIT:
            begin
                if (mul_stat.done)
                begin
                    res_next = mul_product;
                    if (exp_reg[W-1])
                    begin
                        state_next = mexp_pkg::ST_MUL_ISSUE;
                    end
                    else if (cnt_reg == LAST_BIT)
                    begin
                        state_next = mexp_pkg::ST_DELIVER;
                    end
                    else
                    begin
                        exp_next   = {exp_reg[W-2:0], 1'b0};
                        cnt_next   = cnt_reg + CW'(1);
                        state_next = mexp_pkg::ST_SQ_ISSUE;
                    end
                end
            end
            mexp_pkg::ST_MUL_ISSUE:
            begin
                mul_ctrl.start = 1'b1;
                mul_b          = base_reg;
                state_next     = mexp_pkg::ST_MUL_WAIT;
            end
            mexp_pkg::ST_MUL_WAIT:
            begin
                if (mul_stat.done)
                begin
                    res_next = mul_product;
                    if (cnt_reg == LAST_BIT)
                    begin
                        state_next = mexp_pkg::ST_DELIVER;
                    end
                    else
                    begin
                        exp_next   = {exp_reg[W-2:0], 1'b0};
                        cnt_next   = cnt_reg + CW'(1);
                        state_next = mexp_pkg::ST_SQ_ISSUE;
                    end
                end
            end
            mexp_pkg::ST_DELIVER:
            begin
                if (out_free)
                begin
                    result_next    = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = mexp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mexp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mexp_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            modulus_reg   <= mexp_pkg::RESET_MODULUS[W-1:0];
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (modulus_write)
            begin
                modulus_reg <= modulus;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg   <= base_next;
        exp_reg    <= exp_next;
        cnt_reg    <= cnt_next;
        res_reg    <= res_next;
        result_reg <= result_next;
    end

    assign in_stall     = (state_reg != mexp_pkg::ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign power_result = result_reg;

endmodule

`default_nettype wire

@@ bench/mexp_result_checker.sv @@
// Checker that predicts and compares every result of the modular exponentiation core.
`timescale 1ns / 1ps
`default_nettype none

module mexp_result_checker #(
    parameter int OPERAND_WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     modulus_write,
    input  wire logic [OPERAND_WIDTH-1:0] modulus,
    input  wire logic                     in_valid,
    input  wire logic                     in_stall,
    input  wire logic [OPERAND_WIDTH-1:0] base_value,
    input  wire logic [OPERAND_WIDTH-1:0] exponent,
    input  wire logic                     out_valid,
    input  wire logic                     out_stall,
    input  wire logic [OPERAND_WIDTH-1:0] power_result,
    output int                            fail_count,
    output int                            pending
);

    localparam int W = OPERAND_WIDTH;

    typedef logic [W-1:0] word_t;

    typedef struct {
        word_t base_in;
        word_t exp_in;
        word_t mod_in;
        word_t power;
    } power_job_t;

    word_t      modulus_copy;
    power_job_t expected_powers[$];

    function automatic word_t mod_power(word_t b, word_t e, word_t m);
        logic [2*W-1:0] acc;
        logic [2*W-1:0] base_red;
        logic [2*W-1:0] m_wide;
        if (m == '0)
            return '0;
        m_wide = m;
        base_red = b;
        base_red = base_red % m_wide;
        acc = 1;
        acc = acc % m_wide;
        for (int i = W - 1; i >= 0; i--)
        begin
            acc = (acc * acc) % m_wide;
            if (e[i])
                acc = (acc * base_red) % m_wide;
        end
        return acc[W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        power_job_t job;
        if (!rst_n)
        begin
            modulus_copy = mexp_pkg::RESET_MODULUS[W-1:0];
            expected_powers.delete();
            pending = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_powers.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result power_result=%h", $realtime,
                                 power_result);
                end
                else
                begin
                    job = expected_powers.pop_front();
                    if (power_result !== job.power)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: base %h exp %h mod %h: expected %h, got %h",
                                     $realtime, job.base_in, job.exp_in, job.mod_in,
                                     job.power, power_result);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                job.base_in = base_value;
                job.exp_in = exponent;
                job.mod_in = modulus_copy;
                job.power = mod_power(base_value, exponent, modulus_copy);
                expected_powers.push_back(job);
            end
            if (modulus_write)
                modulus_copy = modulus;
            pending = expected_powers.size();
        end
    end

endmodule

`default_nettype wire

@@ bench/tb_modular_exponentiation_core.sv @@
// Testbench top for the modular exponentiation core: stimulus, stall pressure and verdict.
`timescale 1ns / 1ps
`default_nettype none

module tb_modular_exponentiation_core;

    localparam int W = 32;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int HOLD_CYCLES = 6000;
    localparam int RANDOM_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 34;
    localparam int SETTLE_CYCLES = 2400;
    localparam logic [W-1:0] ALL_ONES = '1;
    localparam logic [W-1:0] RESET_MOD = mexp_pkg::RESET_MODULUS[W-1:0];

    typedef logic [W-1:0] word_t;

    logic  clk = 1'b0;
    logic  rst_n;
    logic  modulus_write;
    word_t modulus;
    logic  in_valid;
    logic  in_stall;
    word_t base_value;
    word_t exponent;
    logic  out_valid;
    logic  out_stall;
    word_t power_result;

    int    fail_count;
    int    pending;
    int    cycle_count = 0;
    bit    hold_req = 1'b0;
    bit    no_gaps = 1'b0;
    word_t cur_modulus = RESET_MOD;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    modular_exponentiation_core #(
        .OPERAND_WIDTH(W)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .modulus_write(modulus_write),
        .modulus      (modulus),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .base_value   (base_value),
        .exponent     (exponent),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .power_result (power_result)
    );

    mexp_result_checker #(
        .OPERAND_WIDTH(W)
    ) checker_inst (
        .clk          (clk),
        .rst_n        (rst_n),
        .modulus_write(modulus_write),
        .modulus      (modulus),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .base_value   (base_value),
        .exponent     (exponent),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .power_result (power_result),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 6);
        return $urandom_range(30, 1500);
    endfunction

    function automatic word_t rand_base(word_t m);
        case ($urandom_range(0, 5))
            0, 1: return $urandom;
            2: return $urandom_range(0, 15);
            3: return m - $urandom_range(0, 2);
            4: return m + $urandom_range(0, 2);
            default: return ~(word_t'(1) << $urandom_range(0, W - 1));
        endcase
    endfunction

    function automatic word_t rand_exponent();
        case ($urandom_range(0, 5))
            0, 1: return $urandom;
            2: return $urandom_range(0, 8);
            3: return ALL_ONES ^ ($urandom & $urandom & $urandom);
            4: return word_t'(1) << $urandom_range(0, W - 1);
            default: return $urandom >> $urandom_range(0, W - 1);
        endcase
    endfunction

    task automatic send_item(input word_t b, input word_t e);
        int gap;
        base_value <= b;
        exponent <= e;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_modulus(input word_t value);
        modulus <= value;
        modulus_write <= 1'b1;
        @(negedge clk);
        modulus_write <= 1'b0;
        @(negedge clk);
        cur_modulus = value;
    endtask

    initial
    begin : receiver
        int stall_len;
        int run_len;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall <= 1'b0;
                hold_req = 1'b0;
            end
            else
            begin
                stall_len = ($urandom_range(0, 99) < 70) ? 0 :
                            ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) :
                            $urandom_range(1, 4);
                run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 400) :
                          $urandom_range(0, 10);
                if (stall_len > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (stall_len) @(negedge clk);
                    out_stall <= 1'b0;
                end
                repeat (run_len) @(negedge clk);
            end
        end
    end

    initial
    begin
        word_t m;
        rst_n = 1'b0;
        modulus_write = 1'b0;
        modulus = '0;
        in_valid = 1'b0;
        base_value = '0;
        exponent = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        send_item('0, '0);
        send_item('0, 1);
        send_item(1, ALL_ONES);
        send_item(ALL_ONES, ALL_ONES);
        send_item(ALL_ONES, '0);
        send_item(RESET_MOD, 5);
        send_item(RESET_MOD - 1, 2);
        send_item(RESET_MOD + 1, ALL_ONES);
        send_item(2, 31);
        send_item(2, 32);
        send_item(3, 32'h8000_0000);
        send_item(12345, 1);
        send_item(ALL_ONES, 1);
        drain_results();
        write_modulus(1);
        send_item(ALL_ONES, ALL_ONES);
        send_item(5, '0);
        drain_results();
        write_modulus(ALL_ONES);
        send_item(ALL_ONES - 1, ALL_ONES);
        send_item(ALL_ONES, 7);
        send_item(2, 32'hAAAA_AAAA);
        drain_results();
        write_modulus(2);
        send_item(3, '0);
        send_item(7, ALL_ONES);

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            drain_results();
            case (phase)
                0: m = $urandom;
                1: m = 32'hFFFF_FFFB;
                2: m = $urandom_range(2, 255);
                3: m = 1;
                4: m = $urandom_range(1, 65535);
                5: m = ALL_ONES;
                6: m = $urandom | 32'h8000_0000;
                default: m = RESET_MOD;
            endcase
            if (m == '0)
                m = 1;
            write_modulus(m);
            if (phase == 2)
            begin
                no_gaps = 1'b1;
                hold_req = 1'b1;
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_item(rand_base(cur_modulus), rand_exponent());
            no_gaps = 1'b0;
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
